// File: rtl/tcv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Theremin oscillator package
// Shared widths, register indexes, structs and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package tcv_pkg;

   localparam int SINE_TABLE_BITS = 10;
   localparam int PHASE_BITS      = 32;

   localparam int QUARTER_LEN = 1 << SINE_TABLE_BITS;
   localparam int ROM_ADDR_W  = SINE_TABLE_BITS + 1;

   localparam int READING_W = 16;
   localparam int STEP_W    = 20;
   localparam int SAMPLE_W  = 16;
   localparam int MAG_W     = 15;
   localparam int NUMER_W   = 32;

   // Shared multiplier: 16-bit operand A times 24-bit operand B.
   localparam int MUL_A_W = 16;
   localparam int MUL_B_W = 24;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   // Phase increment is (frequency * step) >> 6.
   localparam int ADV_W = READING_W + STEP_W - 6;

   localparam logic [15:0] FREQ_MIN_Q6  = 16'd6400;
   localparam logic [15:0] FREQ_SPAN_Q6 = 16'd57600;
   localparam logic [15:0] FREQ_MAX_Q6  = 16'd64000;
   localparam logic [15:0] AMP_MAX      = 16'd65535;

   // floor(f * 16 / 25) equals floor(f * CV_MULT / 2^CV_SHIFT) for every 16-bit f.
   localparam logic [MUL_B_W-1:0] CV_MULT = 24'd10737419;
   localparam int CV_SHIFT = 24;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   // Rounded-up reciprocals of the Taylor denominators. Every term numerator
   // stays below 2^33, so the scaled product floors to the exact quotient.
   localparam int          TAYLOR_SHIFT   = 48;
   localparam logic [63:0] TAYLOR_ONE     = 64'd1 << TAYLOR_SHIFT;
   localparam logic [63:0] TAYLOR_RECIP_1 = (TAYLOR_ONE + 64'd5) / 64'd6;
   localparam logic [63:0] TAYLOR_RECIP_2 = (TAYLOR_ONE + 64'd19) / 64'd20;
   localparam logic [63:0] TAYLOR_RECIP_3 = (TAYLOR_ONE + 64'd41) / 64'd42;
   localparam logic [63:0] TAYLOR_RECIP_4 = (TAYLOR_ONE + 64'd71) / 64'd72;
   localparam logic [63:0] TAYLOR_RECIP_5 = (TAYLOR_ONE + 64'd109) / 64'd110;
   localparam logic [63:0] TAYLOR_RECIP_6 = (TAYLOR_ONE + 64'd155) / 64'd156;
   localparam logic [63:0] TAYLOR_RECIP_7 = (TAYLOR_ONE + 64'd209) / 64'd210;

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_PITCH_LOW  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PITCH_HIGH = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_LOW   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN_HIGH  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_STEP_HZ    = 3'd4;

   localparam logic [READING_W-1:0] PITCH_LOW_RESET  = 16'd655;
   localparam logic [READING_W-1:0] PITCH_HIGH_RESET = 16'd28836;
   localparam logic [READING_W-1:0] GAIN_LOW_RESET   = 16'd9861;
   localparam logic [READING_W-1:0] GAIN_HIGH_RESET  = 16'd13959;
   localparam logic [STEP_W-1:0]    STEP_HZ_RESET    = 20'd97391;

   typedef struct packed {
      logic [READING_W-1:0] pitch_window_low;
      logic [READING_W-1:0] pitch_window_high;
      logic [READING_W-1:0] gain_window_low;
      logic [READING_W-1:0] gain_window_high;
      logic [STEP_W-1:0]    step_per_hertz;
   } cfg_type;

   typedef struct packed {
      logic                 start;
      logic [NUMER_W-1:0]   numer;
      logic [READING_W-1:0] denom;
   } div_req_type;

   typedef logic [MAG_W-1:0] sine_table_type [0:QUARTER_LEN];

   function automatic logic [63:0] taylor_recip(input int k);
      unique case (k)
         1: return TAYLOR_RECIP_1;
         2: return TAYLOR_RECIP_2;
         3: return TAYLOR_RECIP_3;
         4: return TAYLOR_RECIP_4;
         5: return TAYLOR_RECIP_5;
         6: return TAYLOR_RECIP_6;
         7: return TAYLOR_RECIP_7;
         default: return '0;
      endcase
   endfunction

   // Eight-term Taylor series of sine on a Q30 angle, rounded to Q15.
   function automatic logic [MAG_W-1:0] sine_q15(input logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic [63:0]        rounded;
      logic [127:0]       scaled;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int k = 1; k <= 7; k++) begin
         scaled = 128'((term * x2) >> 30) * 128'(taylor_recip(k));
         term   = scaled[TAYLOR_SHIFT+63:TAYLOR_SHIFT];
         if ((k & 1) != 0) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      rounded = (64'(sum) + 64'd16384) >> 15;
      if (rounded > 64'd32767) begin
         rounded = 64'd32767;
      end
      return rounded[MAG_W-1:0];
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type tbl;
      logic [63:0]    x;
      for (int i = 0; i <= QUARTER_LEN; i++) begin
         x = (64'(i) * HALF_PI_Q30 + 64'(QUARTER_LEN / 2)) >> SINE_TABLE_BITS;
         tbl[i] = sine_q15(x);
      end
      return tbl;
   endfunction

   localparam sine_table_type SINE_QUARTER = build_sine_table();

endpackage

// File: rtl/tcv_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sensor frame channel
// Carries one pitch reading and one gain reading per word.
// ----------------------------------------------------------------------------
interface tcv_req_if;
   logic                          valid;
   logic                          ready;
   logic [tcv_pkg::READING_W-1:0] pitch_reading;
   logic [tcv_pkg::READING_W-1:0] gain_reading;

   modport source (output valid, output pitch_reading, output gain_reading, input ready);
   modport sink (input valid, input pitch_reading, input gain_reading, output ready);
endinterface

// File: rtl/tcv_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Oscillator result channel
// Carries the audio sample, control voltage and frequency per word.
// ----------------------------------------------------------------------------
interface tcv_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [tcv_pkg::SAMPLE_W-1:0] audio_sample;
   logic [15:0]                         control_voltage;
   logic [15:0]                         pitch_hertz;

   modport source (output valid, output audio_sample, output control_voltage,
                   output pitch_hertz, input ready);
   modport sink (input valid, input audio_sample, input control_voltage,
                 input pitch_hertz, output ready);
endinterface

// File: rtl/tcv_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries a register index and its write data.
// ----------------------------------------------------------------------------
interface tcv_csr_if;
   logic                            valid;
   logic                            ready;
   logic [tcv_pkg::CSR_INDEX_W-1:0] index;
   logic [tcv_pkg::STEP_W-1:0]      data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/tcv_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the pitch and gain windows and the phase step per hertz.
// ----------------------------------------------------------------------------
module tcv_csr (
   input  logic             clock,
   input  logic             reset,
   tcv_csr_if.sink          csr_ch,
   output tcv_pkg::cfg_type cfg
);

   tcv_pkg::cfg_type cfg_ff;
   tcv_pkg::cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.index)
            tcv_pkg::CSR_PITCH_LOW:  cfg_in.pitch_window_low  = csr_ch.data[15:0];
            tcv_pkg::CSR_PITCH_HIGH: cfg_in.pitch_window_high = csr_ch.data[15:0];
            tcv_pkg::CSR_GAIN_LOW:   cfg_in.gain_window_low   = csr_ch.data[15:0];
            tcv_pkg::CSR_GAIN_HIGH:  cfg_in.gain_window_high  = csr_ch.data[15:0];
            tcv_pkg::CSR_STEP_HZ:    cfg_in.step_per_hertz    = csr_ch.data;
            default: begin
               // Writes to unused indexes are dropped.
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pitch_window_low  <= tcv_pkg::PITCH_LOW_RESET;
         cfg_ff.pitch_window_high <= tcv_pkg::PITCH_HIGH_RESET;
         cfg_ff.gain_window_low   <= tcv_pkg::GAIN_LOW_RESET;
         cfg_ff.gain_window_high  <= tcv_pkg::GAIN_HIGH_RESET;
         cfg_ff.step_per_hertz    <= tcv_pkg::STEP_HZ_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/tcv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider
// Radix-2 divider producing a 16-bit quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module tcv_div (
   input  logic                          clock,
   input  logic                          reset,
   input  tcv_pkg::div_req_type          req,
   output logic                          done,
   output logic [tcv_pkg::READING_W-1:0] quotient
);

   localparam int W = tcv_pkg::READING_W;
   localparam int CNT_W = $clog2(W);

   logic [W-1:0]     rem_ff, rem_in;
   logic [W-1:0]     shreg_ff, shreg_in;
   logic [W-1:0]     denom_ff, denom_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [W:0]       trial;
   logic [W:0]       diff;
   logic             qbit;

   assign done     = done_ff;
   assign quotient = shreg_ff;

   // The upper half of the numerator is below the divisor whenever the
   // quotient is used, so it seeds the partial remainder directly.
   always_comb begin
      trial = {rem_ff, shreg_ff[W-1]};
      diff  = trial - {1'b0, denom_ff};
      qbit  = (trial >= {1'b0, denom_ff});

      rem_in   = rem_ff;
      shreg_in = shreg_ff;
      denom_in = denom_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (req.start) begin
         rem_in   = req.numer[2*W-1:W];
         shreg_in = req.numer[W-1:0];
         denom_in = req.denom;
         cnt_in   = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = qbit ? diff[W-1:0] : trial[W-1:0];
         shreg_in = {shreg_ff[W-2:0], qbit};
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff   <= rem_in;
      shreg_ff <= shreg_in;
      denom_ff <= denom_in;
   end

endmodule

// File: rtl/tcv_sine_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quarter-wave sine ROM
// Mirrors the index in odd quadrants and returns the magnitude, registered.
// ----------------------------------------------------------------------------
module tcv_sine_rom (
   input  logic                                clock,
   input  logic                                quad_odd,
   input  logic [tcv_pkg::SINE_TABLE_BITS-1:0] idx,
   output logic [tcv_pkg::MAG_W-1:0]           mag
);

   localparam int AW = tcv_pkg::ROM_ADDR_W;
   localparam logic [AW-1:0] QUARTER_LEN_A = AW'(tcv_pkg::QUARTER_LEN);

   logic [AW-1:0]             addr;
   logic [tcv_pkg::MAG_W-1:0] mag_ff;

   assign addr = quad_odd ? (QUARTER_LEN_A - {1'b0, idx}) : {1'b0, idx};
   assign mag  = mag_ff;

   always_ff @(posedge clock) begin
      mag_ff <= tcv_pkg::SINE_QUARTER[addr];
   end

endmodule

// File: rtl/theremin_oscillator_cv.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Theremin oscillator with control-voltage output
// Maps pitch and gain readings, emits one sine sample and advances the phase.
// ----------------------------------------------------------------------------
//   Channel   Dir  Word contents
//   req_ch    in   pitch_reading, gain_reading (unsigned Q0.16)
//   rsp_ch    out  audio_sample (Q1.15), control_voltage (Q3.13), pitch_hertz (Q10.6)
//   csr_ch    in   index, data (register write, always ready)
//
// A new word is accepted only once the last has finished: req_ch.ready
// returns in the same cycle as its result becomes valid. Two 16-step
// divisions run in the shared restoring divider; one shared multiplier
// handles the remaining products, one per cycle. Reset clears the phase
// and loads the default windows. A stalled result holds the block in its
// last step; the next word can already be accepted while a result waits.
// ----------------------------------------------------------------------------
module theremin_oscillator_cv (
   input  logic      clock,
   input  logic      reset,
   tcv_req_if.sink   req_ch,
   tcv_rsp_if.source rsp_ch,
   tcv_csr_if.sink   csr_ch
);

   localparam int RW = tcv_pkg::READING_W;
   localparam int PB = tcv_pkg::PHASE_BITS;

   typedef enum logic [7:0] {
      ST_IDLE       = 8'b0000_0001,
      ST_MUL_PITCH  = 8'b0000_0010,
      ST_WAIT_PITCH = 8'b0000_0100,
      ST_START_GAIN = 8'b0000_1000,
      ST_WAIT_GAIN  = 8'b0001_0000,
      ST_MUL_AUDIO  = 8'b0010_0000,
      ST_MUL_STEP   = 8'b0100_0000,
      ST_FINISH     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   tcv_pkg::cfg_type     cfg;
   tcv_pkg::div_req_type div_req;
   logic                 div_done;
   logic [RW-1:0]        div_quot;

   logic [RW-1:0] pitch_rd_ff, pitch_rd_in;
   logic [RW-1:0] gain_rd_ff, gain_rd_in;
   logic [RW-1:0] freq_ff, freq_in;
   logic [RW-1:0] amp_ff, amp_in;
   logic [tcv_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic [PB-1:0] phase_ff, phase_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [tcv_pkg::SAMPLE_W-1:0] rsp_sample_ff, rsp_sample_in;
   logic [15:0]                  rsp_cv_ff, rsp_cv_in;
   logic [15:0]                  rsp_freq_ff, rsp_freq_in;

   logic [tcv_pkg::MUL_A_W-1:0] mul_a;
   logic [tcv_pkg::MUL_B_W-1:0] mul_b;
   logic [tcv_pkg::PROD_W-1:0]  mul_p;

   logic [tcv_pkg::MAG_W-1:0] sine_mag;
   logic [tcv_pkg::ADV_W-1:0] phase_adv;

   logic [RW-1:0] pitch_d, pitch_span, gain_d, gain_span;
   logic          pitch_below, pitch_above, gain_below, gain_above;
   logic [tcv_pkg::MAG_W-1:0] audio_mag;
   logic          out_free;

   tcv_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   tcv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quot)
   );

   tcv_sine_rom u_rom (
      .clock    (clock),
      .quad_odd (phase_ff[PB-2]),
      .idx      (phase_ff[PB-3 -: tcv_pkg::SINE_TABLE_BITS]),
      .mag      (sine_mag)
   );

   // Window arithmetic. An empty or inverted window pins the reading low.
   assign pitch_d     = pitch_rd_ff - cfg.pitch_window_low;
   assign pitch_span  = cfg.pitch_window_high - cfg.pitch_window_low;
   assign pitch_below = (cfg.pitch_window_high <= cfg.pitch_window_low) ||
                        (pitch_rd_ff <= cfg.pitch_window_low);
   assign pitch_above = (pitch_d >= pitch_span);
   assign gain_d      = gain_rd_ff - cfg.gain_window_low;
   assign gain_span   = cfg.gain_window_high - cfg.gain_window_low;
   assign gain_below  = (cfg.gain_window_high <= cfg.gain_window_low) ||
                        (gain_rd_ff <= cfg.gain_window_low);
   assign gain_above  = (gain_d >= gain_span);

   assign mul_p     = tcv_pkg::PROD_W'(mul_a) * tcv_pkg::PROD_W'(mul_b);
   assign phase_adv = mul_p[tcv_pkg::ADV_W+5:6];
   assign audio_mag = mul_p[tcv_pkg::MAG_W+15:16];
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready           = (state_ff == ST_IDLE);
   assign rsp_ch.valid           = rsp_valid_ff;
   assign rsp_ch.audio_sample    = rsp_sample_ff;
   assign rsp_ch.control_voltage = rsp_cv_ff;
   assign rsp_ch.pitch_hertz     = rsp_freq_ff;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_MUL_PITCH: begin
            mul_a = pitch_d;
            mul_b = tcv_pkg::MUL_B_W'(tcv_pkg::FREQ_SPAN_Q6);
         end
         ST_MUL_AUDIO: begin
            mul_a = amp_ff;
            mul_b = tcv_pkg::MUL_B_W'(sine_mag);
         end
         ST_MUL_STEP: begin
            mul_a = freq_ff;
            mul_b = tcv_pkg::MUL_B_W'(cfg.step_per_hertz);
         end
         ST_FINISH: begin
            mul_a = freq_ff;
            mul_b = tcv_pkg::CV_MULT;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      pitch_rd_in   = pitch_rd_ff;
      gain_rd_in    = gain_rd_ff;
      freq_in       = freq_ff;
      amp_in        = amp_ff;
      sample_in     = sample_ff;
      phase_in      = phase_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_cv_in     = rsp_cv_ff;
      rsp_freq_in   = rsp_freq_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      div_req       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               pitch_rd_in = req_ch.pitch_reading;
               gain_rd_in  = req_ch.gain_reading;
               state_in    = ST_MUL_PITCH;
            end
         end
         ST_MUL_PITCH: begin
            div_req.start = 1'b1;
            div_req.numer = mul_p[tcv_pkg::NUMER_W-1:0];
            div_req.denom = pitch_span;
            state_in      = ST_WAIT_PITCH;
         end
         ST_WAIT_PITCH: begin
            if (div_done) begin
               priority if (pitch_below) begin
                  freq_in = tcv_pkg::FREQ_MIN_Q6;
               end else if (pitch_above) begin
                  freq_in = tcv_pkg::FREQ_MAX_Q6;
               end else begin
                  freq_in = tcv_pkg::FREQ_MIN_Q6 + div_quot;
               end
               state_in = ST_START_GAIN;
            end
         end
         ST_START_GAIN: begin
            div_req.start = 1'b1;
            div_req.numer = {gain_d, {RW{1'b0}}};
            div_req.denom = gain_span;
            state_in      = ST_WAIT_GAIN;
         end
         ST_WAIT_GAIN: begin
            if (div_done) begin
               priority if (gain_below) begin
                  amp_in = '0;
               end else if (gain_above) begin
                  amp_in = tcv_pkg::AMP_MAX;
               end else begin
                  amp_in = div_quot;
               end
               state_in = ST_MUL_AUDIO;
            end
         end
         ST_MUL_AUDIO: begin
            // The sign comes from the upper half of the turn.
            if (phase_ff[PB-1]) begin
               sample_in = '0 - {1'b0, audio_mag};
            end else begin
               sample_in = {1'b0, audio_mag};
            end
            state_in = ST_MUL_STEP;
         end
         ST_MUL_STEP: begin
            phase_in = phase_ff + PB'(phase_adv);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_sample_in = sample_ff;
               rsp_cv_in     = mul_p[tcv_pkg::CV_SHIFT+15:tcv_pkg::CV_SHIFT];
               rsp_freq_in   = freq_ff;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pitch_rd_ff   <= pitch_rd_in;
      gain_rd_ff    <= gain_rd_in;
      freq_ff       <= freq_in;
      amp_ff        <= amp_in;
      sample_ff     <= sample_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_cv_ff     <= rsp_cv_in;
      rsp_freq_ff   <= rsp_freq_in;
   end

endmodule
